// ===== sv/vlos_pkg.sv =====
// Shared types, constants and helpers of the voxel line-of-sight block.
package vlos_pkg;

   // Voxels along each axis are 2**AXIS_BITS; the request fields stay 5 bits wide.
   localparam int AXIS_BITS   = 5;
   localparam int FIELD_W     = 5;
   localparam int ADDR_W      = 3 * AXIS_BITS;
   localparam int MAP_DEPTH   = 1 << ADDR_W;
   localparam int ERR_W       = AXIS_BITS + 3;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef logic [FIELD_W-1:0]   field_type;
   typedef logic [AXIS_BITS-1:0] coord_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [ERR_W-1:0]     err_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_GOAL,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic map_wr;
      logic latch;
      logic rd_start;
      logic init_err;
      logic rd_goal;
      logic rd_walk;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic walk_empty;
      logic walk_last;
   } status_type;

   // Request coordinates are reduced to (or widened to) the axis width.
   function automatic coord_type to_coord(field_type f);
      return coord_type'(f);
   endfunction

   function automatic addr_type voxel_addr(coord_type x, coord_type y, coord_type z);
      return {z, y, x};
   endfunction

endpackage

// ===== sv/vlos_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module vlos_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/vlos_ctrl.sv =====
// Controller state machine: clearing pass, request dispatch, walk sequencing, result hand-off.
module vlos_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_kind,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  vlos_pkg::status_type status,
   output vlos_pkg::cmd_type    cmd,
   output vlos_pkg::state_type  state
);
   import vlos_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_kind == REQ_QUERY) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = ST_GOAL;
         ST_GOAL: begin
            state_in = status.walk_empty ? ST_DONE : ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            if (accept) begin
               cmd.map_wr = (req_kind == REQ_WRITE);
               cmd.latch  = (req_kind == REQ_QUERY);
            end
         end
         ST_START: begin
            cmd.rd_start = 1'b1;
            cmd.init_err = 1'b1;
         end
         ST_GOAL: cmd.rd_goal = 1'b1;
         ST_WALK: cmd.rd_walk = 1'b1;
         ST_DONE: cmd.load_rsp = rsp_free;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign state      = state_ff;

endmodule

// ===== sv/vlos_dp.sv =====
// Datapath: occupancy map, Bresenham walk registers, blocked flag and result register.
module vlos_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  vlos_pkg::cmd_type    cmd,
   output vlos_pkg::status_type status,
   input  vlos_pkg::field_type  start_x,
   input  vlos_pkg::field_type  start_y,
   input  vlos_pkg::field_type  start_z,
   input  vlos_pkg::field_type  end_x,
   input  vlos_pkg::field_type  end_y,
   input  vlos_pkg::field_type  end_z,
   input  logic                 occupied_value,
   output logic                 line_clear
);
   import vlos_pkg::*;

   coord_type a_q [3];
   coord_type g_q [3];
   coord_type dlt_q [3];
   logic [2:0] drv_q;
   coord_type dmax_q;

   coord_type p_ff [3];
   coord_type p_in [3];
   coord_type g_ff [3];
   coord_type g_in [3];
   coord_type dlt_ff [3];
   coord_type dlt_in [3];
   err_type   err_ff [3];
   err_type   err_in [3];
   logic [2:0] up_ff, up_in;
   logic [2:0] drv_ff, drv_in;
   coord_type dmax_ff, dmax_in;
   coord_type cnt_ff, cnt_in;
   logic      clear_ff, clear_in;

   addr_type  clr_ff, clr_in;
   logic      pending_ff, pending_in;
   logic      blocked_ff, blocked_in;

   err_type   two_d;
   err_type   two_dk;
   logic [2:0] minor_step;

   logic      wr_en;
   addr_type  wr_addr;
   logic [0:0] wr_data;
   logic      rd_en;
   addr_type  rd_addr;
   logic [0:0] rd_data;

   // Deltas, directions and the driving axis of the incoming request.
   always_comb begin
      a_q[0] = to_coord(start_x);
      a_q[1] = to_coord(start_y);
      a_q[2] = to_coord(start_z);
      g_q[0] = to_coord(end_x);
      g_q[1] = to_coord(end_y);
      g_q[2] = to_coord(end_z);
      for (int k = 0; k < 3; k++) begin
         dlt_q[k] = (a_q[k] > g_q[k]) ? a_q[k] - g_q[k] : g_q[k] - a_q[k];
      end
      priority if (dlt_q[0] >= dlt_q[1] && dlt_q[0] >= dlt_q[2]) begin
         drv_q  = 3'b001;
         dmax_q = dlt_q[0];
      end else if (dlt_q[1] >= dlt_q[2]) begin
         drv_q  = 3'b010;
         dmax_q = dlt_q[1];
      end else begin
         drv_q  = 3'b100;
         dmax_q = dlt_q[2];
      end
   end

   assign two_d = {2'b00, dmax_ff, 1'b0};

   // A minor axis steps when its error term is strictly positive.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         minor_step[k] = !drv_ff[k] && !err_ff[k][ERR_W-1] && (err_ff[k] != '0);
      end
   end

   always_comb begin
      two_dk   = '0;
      up_in    = up_ff;
      drv_in   = drv_ff;
      dmax_in  = dmax_ff;
      cnt_in   = cnt_ff;
      clear_in = clear_ff;
      for (int k = 0; k < 3; k++) begin
         p_in[k]   = p_ff[k];
         g_in[k]   = g_ff[k];
         dlt_in[k] = dlt_ff[k];
         err_in[k] = err_ff[k];
      end
      if (cmd.latch) begin
         for (int k = 0; k < 3; k++) begin
            p_in[k]   = a_q[k];
            g_in[k]   = g_q[k];
            dlt_in[k] = dlt_q[k];
            up_in[k]  = (a_q[k] < g_q[k]);
         end
         drv_in  = drv_q;
         dmax_in = dmax_q;
         cnt_in  = dmax_q;
      end
      if (cmd.init_err) begin
         for (int k = 0; k < 3; k++) begin
            err_in[k] = {2'b00, dlt_ff[k], 1'b0} - {3'b000, dmax_ff};
         end
      end
      if (cmd.rd_walk) begin
         cnt_in = cnt_ff - coord_type'(1);
         for (int k = 0; k < 3; k++) begin
            two_dk    = {2'b00, dlt_ff[k], 1'b0};
            err_in[k] = err_ff[k] - (minor_step[k] ? two_d : err_type'(0)) + two_dk;
            if (drv_ff[k] || minor_step[k]) begin
               p_in[k] = up_ff[k] ? p_ff[k] + coord_type'(1) : p_ff[k] - coord_type'(1);
            end
         end
      end
      if (cmd.load_rsp) begin
         clear_in = !(blocked_ff || (pending_ff && rd_data[0]));
      end
   end

   always_comb begin
      clr_in     = cmd.clear_wr ? clr_ff + addr_type'(1) : clr_ff;
      pending_in = rd_en;
      blocked_in = blocked_ff || (pending_ff && rd_data[0]);
      if (cmd.latch) begin
         blocked_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         pending_ff <= 1'b0;
         blocked_ff <= 1'b0;
      end else begin
         clr_ff     <= clr_in;
         pending_ff <= pending_in;
         blocked_ff <= blocked_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff     <= p_in;
      g_ff     <= g_in;
      dlt_ff   <= dlt_in;
      err_ff   <= err_in;
      up_ff    <= up_in;
      drv_ff   <= drv_in;
      dmax_ff  <= dmax_in;
      cnt_ff   <= cnt_in;
      clear_ff <= clear_in;
   end

   assign wr_en   = cmd.clear_wr || cmd.map_wr;
   assign wr_addr = cmd.clear_wr ? clr_ff : voxel_addr(a_q[0], a_q[1], a_q[2]);
   assign wr_data = cmd.clear_wr ? 1'b0 : occupied_value;
   assign rd_en   = cmd.rd_start || cmd.rd_goal || cmd.rd_walk;
   assign rd_addr = cmd.rd_goal ? voxel_addr(g_ff[0], g_ff[1], g_ff[2])
                                : voxel_addr(p_ff[0], p_ff[1], p_ff[2]);

   vlos_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign status.clear_last = &clr_ff;
   assign status.walk_empty = (cnt_ff == '0);
   assign status.walk_last  = (cnt_ff == coord_type'(1));
   assign line_clear        = clear_ff;

endmodule

// ===== sv/voxel_line_of_sight.sv =====
// Top level of the voxel line-of-sight block: stream ports, controller and datapath.
//
// Channel   Direction  Beat contents
// req_      in         tuser: req_type; tdata: start_x/y/z, end_x/y/z, occupied_value
// rsp_      out        tdata: line_clear (one beat per query, none per write)
//
// A write is taken in the idle state. A query reads the start voxel, the goal voxel
// and each of the d walked voxels, d being the largest axis delta (31 at most), with
// one map read per cycle on the single read port.
// After reset the map is cleared one voxel a cycle, all 32768 voxels, with req_tready low.
// A finished result waits in the output register; a new request is taken meanwhile,
// and a query finishing behind a stalled result holds until that beat is taken.
module voxel_line_of_sight (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_x[4:0], start_y[9:5], start_z[14:10], end_x[19:15], end_y[24:20],
   // end_z[29:25], occupied_value[30], zero[31]
   input  logic [vlos_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // line_clear[0], zero[7:1]
   output logic [vlos_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import vlos_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;
   logic       line_clear;

   vlos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .state      (state)
   );

   vlos_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .start_x        (req_tdata[4:0]),
      .start_y        (req_tdata[9:5]),
      .start_z        (req_tdata[14:10]),
      .end_x          (req_tdata[19:15]),
      .end_y          (req_tdata[24:20]),
      .end_z          (req_tdata[29:25]),
      .occupied_value (req_tdata[30]),
      .line_clear     (line_clear)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-1){1'b0}}, line_clear};

`ifndef SYNTHESIS
   // A result beat only appears after a query has finished its walk.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state == ST_DONE))
      else $error("result raised outside the done state");

   // The walk counter never underflows while walking.
   a_walk_count: assert property (@(posedge clock) disable iff (reset)
      (state == ST_WALK) |-> !status.walk_empty)
      else $error("walk entered with no steps left");

   // The clearing pass runs only once after reset.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state != ST_CLEAR) |=> (state != ST_CLEAR))
      else $error("clearing pass restarted");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking stream testbench for the voxel line-of-sight block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import vlos_pkg::*;

   localparam int AXIS_MASK      = (1 << AXIS_BITS) - 1;
   localparam int RANDOM_ITEMS   = 600;
   localparam int HOLDOFF_AT     = 150;   // queries accepted before the long receiver stall
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TAIL_CYCLES    = 60;

   typedef struct {
      logic      kind;
      field_type sx, sy, sz;
      field_type ex, ey, ez;
      logic      occ;
      bit        wait_idle;   // offer this beat only after every result has come back
   } voxel_req_type;

   logic clock;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   voxel_line_of_sight u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   voxel_req_type request_q[$];
   bit         line_clear_q[$];
   bit         voxel_map [MAP_DEPTH];
   int         mismatch_count = 0;
   int         queries_taken  = 0;
   int         results_seen   = 0;
   logic       req_fire       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic addr_type voxel_index(input int x, input int y, input int z);
      return addr_type'((x & AXIS_MASK) | ((y & AXIS_MASK) << AXIS_BITS)
                        | ((z & AXIS_MASK) << (2 * AXIS_BITS)));
   endfunction

   // Walks the Bresenham line over the predicted map, checking both end voxels first.
   function automatic bit predict_line_clear(input int sx, input int sy, input int sz,
                                             input int gx, input int gy, input int gz);
      int a[3], g[3], d[3], s[3], p[3];
      int drv, m1, m2, e1, e2, k, i;
      a = '{sx & AXIS_MASK, sy & AXIS_MASK, sz & AXIS_MASK};
      g = '{gx & AXIS_MASK, gy & AXIS_MASK, gz & AXIS_MASK};
      for (k = 0; k < 3; k++) begin
         d[k] = (a[k] > g[k]) ? a[k] - g[k] : g[k] - a[k];
         s[k] = (a[k] < g[k]) ? 1 : -1;
         p[k] = a[k];
      end
      if (voxel_map[voxel_index(a[0], a[1], a[2])] || voxel_map[voxel_index(g[0], g[1], g[2])])
         return 1'b0;
      if (d[0] >= d[1] && d[0] >= d[2]) begin
         drv = 0; m1 = 1; m2 = 2;
      end else if (d[1] >= d[0] && d[1] >= d[2]) begin
         drv = 1; m1 = 0; m2 = 2;
      end else begin
         drv = 2; m1 = 1; m2 = 0;
      end
      e1 = 2 * d[m1] - d[drv];
      e2 = 2 * d[m2] - d[drv];
      for (i = 0; i < d[drv]; i++) begin
         if (voxel_map[voxel_index(p[0], p[1], p[2])])
            return 1'b0;
         if (e1 > 0) begin
            p[m1] += s[m1];
            e1 -= 2 * d[drv];
         end
         if (e2 > 0) begin
            p[m2] += s[m2];
            e2 -= 2 * d[drv];
         end
         e1 += 2 * d[m1];
         e2 += 2 * d[m2];
         p[drv] += s[drv];
      end
      return 1'b1;
   endfunction

   task automatic add_write(input int x, input int y, input int z, input logic occ);
      voxel_req_type it;
      it.kind = REQ_WRITE;
      it.sx = field_type'(x); it.sy = field_type'(y); it.sz = field_type'(z);
      it.ex = field_type'($urandom_range(0, 31));
      it.ey = field_type'($urandom_range(0, 31));
      it.ez = field_type'($urandom_range(0, 31));
      it.occ = occ;
      it.wait_idle = 1'b0;
      request_q.push_back(it);
   endtask

   task automatic add_query(input int sx, input int sy, input int sz,
                            input int ex, input int ey, input int ez);
      voxel_req_type it;
      it.kind = REQ_QUERY;
      it.sx = field_type'(sx); it.sy = field_type'(sy); it.sz = field_type'(sz);
      it.ex = field_type'(ex); it.ey = field_type'(ey); it.ez = field_type'(ez);
      it.occ = 1'($urandom_range(0, 1));
      it.wait_idle = 1'b0;
      request_q.push_back(it);
   endtask

   // Sender: bursts of beats separated by random gaps, changing at the falling edge.
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      voxel_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // Beat still waiting for acceptance; hold it.
      end else if (gap_left > 0) begin
         req_tvalid <= 1'b0;
         gap_left   <= gap_left - 1;
      end else if (request_q.size() == 0
                   || (request_q[0].wait_idle && line_clear_q.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else begin
         it = request_q.pop_front();
         req_tvalid <= 1'b1;
         req_tuser  <= it.kind;
         req_tdata  <= {1'b0, it.occ, it.ez, it.ey, it.ex, it.sz, it.sy, it.sx};
         if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // Receiver: its own stall pattern, plus one long hold-off that backs up the block.
   int  mode_left    = 0;
   int  ready_mode   = 0;
   int  holdoff_left = 0;
   bit  holdoff_done = 1'b0;

   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && queries_taken >= HOLDOFF_AT) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // Both channels are sampled at the rising edge; the map is updated in acceptance order.
   always @(posedge clock) begin
      bit want;
      req_fire <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         if (req_tuser == REQ_WRITE) begin
            voxel_map[voxel_index(int'(req_tdata[4:0]), int'(req_tdata[9:5]),
                                  int'(req_tdata[14:10]))] = req_tdata[30];
         end else begin
            line_clear_q.push_back(predict_line_clear(int'(req_tdata[4:0]),
                                                      int'(req_tdata[9:5]),
                                                      int'(req_tdata[14:10]),
                                                      int'(req_tdata[19:15]),
                                                      int'(req_tdata[24:20]),
                                                      int'(req_tdata[29:25])));
            queries_taken <= queries_taken + 1;
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (line_clear_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat, tdata %0h", rsp_tdata));
         end else begin
            want = line_clear_q.pop_front();
            if (rsp_tdata[0] !== want)
               report_mismatch($sformatf("result %0d: line_clear %b, expected %b",
                                         results_seen, rsp_tdata[0], want));
            if (rsp_tdata[RSP_TDATA_W-1:1] !== '0)
               report_mismatch($sformatf("result %0d: padding bits %0h not zero",
                                         results_seen, rsp_tdata[RSP_TDATA_W-1:1]));
         end
         results_seen <= results_seen + 1;
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int n, span, bx, by, bz;
      bit wide;
      voxel_req_type it;

      // Directed part: empty map, single voxel, each driving axis, ties, both directions.
      add_query(0, 0, 0, 31, 31, 31);
      add_query(5, 5, 5, 5, 5, 5);
      add_write(31, 31, 31, 1'b1);
      add_query(0, 0, 0, 31, 31, 31);
      add_query(31, 31, 31, 31, 31, 31);
      add_write(10, 0, 0, 1'b1);
      add_query(0, 0, 0, 20, 0, 0);
      add_query(10, 0, 0, 10, 0, 5);
      add_write(0, 15, 0, 1'b1);
      add_query(0, 0, 0, 0, 25, 0);
      add_query(0, 31, 0, 0, 0, 0);
      add_write(0, 0, 16, 1'b1);
      add_query(0, 0, 31, 0, 0, 0);
      add_write(2, 2, 0, 1'b1);
      add_query(0, 0, 0, 4, 4, 0);
      add_query(0, 0, 0, 7, 7, 7);
      add_query(31, 0, 0, 0, 31, 31);
      add_query(4, 0, 0, 0, 4, 4);
      add_write(31, 31, 31, 1'b0);
      add_query(31, 31, 31, 0, 0, 0);
      add_write(10, 0, 0, 1'b0);
      add_query(20, 0, 0, 0, 0, 0);
      add_query(30, 1, 2, 3, 29, 17);

      // Random part: mostly dense local windows so that lines do hit obstacles.
      span = 1; bx = 0; by = 0; bz = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) begin
            span = $urandom_range(1, 4);
            bx = $urandom_range(0, 31);
            by = $urandom_range(0, 31);
            bz = $urandom_range(0, 31);
         end
         wide = ($urandom_range(0, 3) == 0);
         it.kind = ($urandom_range(0, 9) < 4) ? REQ_WRITE : REQ_QUERY;
         it.sx = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(bx + $urandom_range(0, span));
         it.sy = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(by + $urandom_range(0, span));
         it.sz = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(bz + $urandom_range(0, span));
         it.ex = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(bx + $urandom_range(0, span));
         it.ey = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(by + $urandom_range(0, span));
         it.ez = wide ? field_type'($urandom_range(0, 31))
                      : field_type'(bz + $urandom_range(0, span));
         it.occ = ($urandom_range(0, 9) < 7);
         it.wait_idle = (n % 150 == 149);
         request_q.push_back(it);
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || req_tvalid)
         @(posedge clock);
      while (line_clear_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/vlos_pkg.sv
sv/vlos_ram.sv
sv/vlos_ctrl.sv
sv/vlos_dp.sv
sv/voxel_line_of_sight.sv
tb/sv/testbench.sv
